### sv/lla_pkg.sv
`default_nettype none

package lla_pkg;

	typedef enum logic [1:0] {
		ACT_WRITE   = 2'd0,
		ACT_CLEAR   = 2'd1,
		ACT_ADVANCE = 2'd2,
		ACT_READ    = 2'd3
	} act_t;

	localparam int MASK_W = 9;
	localparam int COORD_W = 6;

	localparam logic [MASK_W-1:0] BIRTH_RESET = 9'd8;
	localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;

	localparam logic REG_BIRTH = 1'b0;
	localparam logic REG_SURVIVE = 1'b1;

	// one step of the row window during a generation
	typedef struct packed {
		logic load_prev;
		logic load_first;
		logic shift;
		logic wrap;
	} row_ctrl_t;

endpackage

`default_nettype wire

### sv/life_like_automaton_generation_top.sv
// life-like automaton on a toroidal grid of GRID_HEIGHT rows by GRID_WIDTH cells
//
// requests come in on the s_ group: s_tuser carries the action (write cell,
// clear board, advance one generation, read cell), s_tdata the cell position
// and paint value. every request gives exactly one response on the m_ group,
// echoing the action in m_tuser with the cell value in m_tdata bit 0.
// birth and survival masks are written over the cfg channel (index 0 birth,
// index 1 survival), which is always ready; write them only while idle.
//
// one request is worked on at a time: a write or read goes through the cell
// state, a clear through a pass over the rows, a generation through a row
// pass and the drain and wrap states; rows stream through a three-row window
// at one row per cycle over the row store's single read and single write port.
// s_tready is high only while idle; a finished response sits in the output
// register while the next request is accepted, and the block holds a further
// response until m_tready takes the previous one.
// after reset a clearing pass over GRID_HEIGHT rows zeroes the grid before
// s_tready first rises; the masks return to birth on 3, survive on 2 and 3.
`default_nettype none

module life_like_automaton_generation_top
	import lla_pkg::*;
#(
	parameter int GRID_WIDTH = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,  // column[5:0], row[11:6], paint_value[12]
	input  wire logic [1:0]        s_tuser,  // action
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [7:0]        m_tdata,  // cell_state[0]
	output logic      [1:0]        m_tuser,  // done_action
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [MASK_W-1:0] cfg_data
);

	localparam int RW = $clog2(GRID_HEIGHT);
	localparam int CW = $clog2(GRID_WIDTH);
	localparam int CNTW = $clog2(GRID_HEIGHT + 1);
	localparam logic [CNTW-1:0] CNT_LAST_ROW = CNTW'(GRID_HEIGHT - 1);
	localparam logic [CNTW-1:0] CNT_ROWS = CNTW'(GRID_HEIGHT);
	localparam logic [RW-1:0] LAST_ROW = RW'(GRID_HEIGHT - 1);
	localparam logic [COORD_W:0] W_LIM = (COORD_W + 1)'(GRID_WIDTH);
	localparam logic [10:0] H_LIM = 11'(GRID_HEIGHT);

	typedef enum logic [7:0] {
		ST_INIT  = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_CLEAR = 8'b0000_0100,
		ST_CELL  = 8'b0000_1000,
		ST_GEN   = 8'b0001_0000,
		ST_DRAIN = 8'b0010_0000,
		ST_WRAP  = 8'b0100_0000,
		ST_RESP  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [CNTW-1:0] cnt_q;
	logic [CNTW-1:0] cnt_m1;
	logic [RW-1:0] wr_row_q;
	logic gen_vld_s1;
	logic gen_k0_s1;
	logic gen_k1_s1;

	logic [MASK_W-1:0] birth_q;
	logic [MASK_W-1:0] survive_q;

	act_t act_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic paint_q;
	logic inside_q;
	logic cell_q;

	logic out_valid_q;
	act_t out_act_q;
	logic out_cell_q;

	logic [COORD_W-1:0] s_column;
	logic [COORD_W-1:0] s_row;
	logic s_paint;
	act_t s_act;
	logic accept;
	logic resp_load;

	logic mem_wr_en;
	logic [RW-1:0] mem_wr_addr;
	logic [GRID_WIDTH-1:0] mem_wr_data;
	logic mem_rd_en;
	logic [RW-1:0] mem_rd_addr;
	logic [GRID_WIDTH-1:0] mem_rd_data;
	logic [GRID_WIDTH-1:0] cell_bit;
	logic [GRID_WIDTH-1:0] new_row;
	row_ctrl_t row_ctrl;

	assign s_column = s_tdata[5:0];
	assign s_row = s_tdata[11:6];
	assign s_paint = s_tdata[12];
	assign s_act = act_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign resp_load = (state_q == ST_RESP) && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_act_q;
	assign m_tdata = {7'd0, out_cell_q};

	assign cnt_m1 = cnt_q - 1'b1;

	// masks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q <= BIRTH_RESET;
			survive_q <= SURVIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BIRTH:   birth_q <= cfg_data;
				REG_SURVIVE: survive_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q <= '0;
			wr_row_q <= '0;
			gen_vld_s1 <= 1'b0;
			gen_k0_s1 <= 1'b0;
			gen_k1_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			gen_vld_s1 <= (state_q == ST_GEN);
			gen_k0_s1 <= (cnt_q == '0);
			gen_k1_s1 <= (cnt_q == CNTW'(1));
			if (row_ctrl.shift) begin
				wr_row_q <= wr_row_q + 1'b1;
			end
			if (m_tready && !resp_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					wr_row_q <= '0;
					if (accept) begin
						unique case (s_act)
							ACT_CLEAR:   state_q <= ST_CLEAR;
							ACT_ADVANCE: state_q <= ST_GEN;
							default:     state_q <= ST_CELL;
						endcase
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST_ROW) begin
						state_q <= ST_RESP;
					end
				end
				ST_CELL: state_q <= ST_RESP;
				ST_GEN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_ROWS) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_WRAP;
				ST_WRAP:  state_q <= ST_RESP;
				ST_RESP: begin
					if (resp_load) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

	// request and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= s_act;
			col_q <= CW'(s_column);
			row_q <= RW'(s_row);
			paint_q <= s_paint;
			inside_q <= ({1'b0, s_column} < W_LIM) && (11'(s_row) < H_LIM);
			cell_q <= 1'b0;
		end
		if (state_q == ST_CELL) begin
			cell_q <= (act_q == ACT_READ) && inside_q && mem_rd_data[col_q];
		end
		if (resp_load) begin
			out_act_q <= act_q;
			out_cell_q <= cell_q;
		end
	end

	// row window loads and shifts, in the cycle after each generation read; wrap in the wrap state
	always_comb begin
		row_ctrl.load_prev = gen_vld_s1 && gen_k0_s1;
		row_ctrl.load_first = gen_vld_s1 && gen_k1_s1;
		row_ctrl.shift = gen_vld_s1 && !gen_k0_s1 && !gen_k1_s1;
		row_ctrl.wrap = (state_q == ST_WRAP);
	end

	assign cell_bit = GRID_WIDTH'(1) << col_q;

	// generation reads last row first, then rows 0 up to the last again
	always_comb begin
		mem_rd_en = accept || (state_q == ST_GEN);
		if (state_q == ST_GEN) begin
			mem_rd_addr = (cnt_q == '0) ? LAST_ROW : cnt_m1[RW-1:0];
		end else begin
			mem_rd_addr = RW'(s_row);
		end
	end

	always_comb begin
		mem_wr_en = 1'b0;
		mem_wr_addr = wr_row_q;
		mem_wr_data = new_row;
		unique case (state_q) inside
			ST_INIT, ST_CLEAR: begin
				mem_wr_en = 1'b1;
				mem_wr_addr = cnt_q[RW-1:0];
				mem_wr_data = '0;
			end
			ST_CELL: begin
				mem_wr_en = (act_q == ACT_WRITE) && inside_q;
				mem_wr_addr = row_q;
				mem_wr_data = (mem_rd_data & ~cell_bit) | ({GRID_WIDTH{paint_q}} & cell_bit);
			end
			ST_WRAP: mem_wr_en = 1'b1;
			default: mem_wr_en = row_ctrl.shift;
		endcase
	end

	lla_grid_mem #(
		.GRID_WIDTH(GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT),
		.AW(RW)
	) u_mem (
		.clk(clk),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en(mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	lla_row_unit #(
		.GRID_WIDTH(GRID_WIDTH)
	) u_row (
		.clk(clk),
		.ctrl(row_ctrl),
		.rd_data(mem_rd_data),
		.birth_mask(birth_q),
		.survive_mask(survive_q),
		.new_row(new_row)
	);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_wrap_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRAP) |-> (wr_row_q == LAST_ROW))
		else $error("wrap write does not land on the last row");

	a_window_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		gen_vld_s1 |-> $past(state_q == ST_GEN))
		else $error("row window step without a generation read");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (state_q == ST_INIT || state_q == ST_CLEAR || state_q == ST_CELL
			|| state_q == ST_GEN || state_q == ST_DRAIN || state_q == ST_WRAP))
		else $error("grid write outside a writing state");

endmodule

`default_nettype wire

### sv/lla_grid_mem.sv
`default_nettype none

module lla_grid_mem #(
	parameter int GRID_WIDTH = 64,
	parameter int GRID_HEIGHT = 64,
	parameter int AW = 6
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [GRID_WIDTH-1:0] wr_data,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output logic      [GRID_WIDTH-1:0] rd_data
);

	logic [GRID_WIDTH-1:0] mem_q [GRID_HEIGHT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### sv/lla_row_unit.sv
`default_nettype none

module lla_row_unit
	import lla_pkg::*;
#(
	parameter int GRID_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire row_ctrl_t             ctrl,
	input  wire logic [GRID_WIDTH-1:0] rd_data,
	input  wire logic [MASK_W-1:0]     birth_mask,
	input  wire logic [MASK_W-1:0]     survive_mask,
	output logic      [GRID_WIDTH-1:0] new_row
);

	// three-row window that the grid shifts through one row a cycle
	logic [GRID_WIDTH-1:0] prev_q;
	logic [GRID_WIDTH-1:0] cur_q;
	logic [GRID_WIDTH-1:0] first_q;
	logic [GRID_WIDTH-1:0] below;

	always_ff @(posedge clk) begin
		if (ctrl.load_prev) begin
			prev_q <= rd_data;
		end
		if (ctrl.load_first) begin
			cur_q <= rd_data;
			first_q <= rd_data;
		end
		if (ctrl.shift) begin
			prev_q <= cur_q;
			cur_q <= rd_data;
		end
	end

	// bottom row wraps onto the old top row
	assign below = ctrl.wrap ? first_q : rd_data;

	for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_cell
		localparam int L = (x == 0) ? GRID_WIDTH - 1 : x - 1;
		localparam int R = (x == GRID_WIDTH - 1) ? 0 : x + 1;
		logic [3:0] n;

		assign n = 4'(prev_q[L]) + 4'(prev_q[x]) + 4'(prev_q[R])
			+ 4'(cur_q[L]) + 4'(cur_q[R])
			+ 4'(below[L]) + 4'(below[x]) + 4'(below[R]);
		assign new_row[x] = birth_mask[n] | (cur_q[x] & survive_mask[n]);
	end

endmodule

`default_nettype wire

### tb/sv/life_like_automaton_generation_checker.sv
`timescale 1ns / 1ps

module life_like_automaton_generation_checker
	import lla_pkg::*;
#(
	parameter int GRID_WIDTH = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [15:0]       s_tdata,  // column[5:0], row[11:6], paint_value[12]
	input  logic [1:0]        s_tuser,  // action
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,  // cell_state[0]
	input  logic [1:0]        m_tuser,  // done_action
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [MASK_W-1:0] cfg_data,
	output int                mismatch_count,
	output int                outstanding
);

	typedef struct packed {
		act_t action;
		logic cell_val;
	} reply_t;

	logic [MASK_W-1:0]     birth_rule;
	logic [MASK_W-1:0]     survive_rule;
	logic [GRID_WIDTH-1:0] board [GRID_HEIGHT];
	reply_t                replies_due [$];
	reply_t                due;
	int                    mismatches;
	int                    req_col;
	int                    req_row;
	logic                  req_paint;
	logic                  on_board;

	assign mismatch_count = mismatches;

	// every cell is worked out from a snapshot of the old board
	task automatic step_generation();
		logic [GRID_WIDTH-1:0] old_board [GRID_HEIGHT];
		int y, x, dy, dx, yy, xx, n;
		for (y = 0; y < GRID_HEIGHT; y++)
			old_board[y] = board[y];
		for (y = 0; y < GRID_HEIGHT; y++) begin
			for (x = 0; x < GRID_WIDTH; x++) begin
				n = 0;
				for (dy = -1; dy <= 1; dy++) begin
					for (dx = -1; dx <= 1; dx++) begin
						if (dy != 0 || dx != 0) begin
							yy = (y + dy + GRID_HEIGHT) % GRID_HEIGHT;
							xx = (x + dx + GRID_WIDTH) % GRID_WIDTH;
							n = n + int'(old_board[yy][xx]);
						end
					end
				end
				// birth wins over the survival rule, even for a live cell
				board[y][x] = birth_rule[n] || (old_board[y][x] && survive_rule[n]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_rule = BIRTH_RESET;
			survive_rule = SURVIVE_RESET;
			for (int y = 0; y < GRID_HEIGHT; y++)
				board[y] = '0;
			replies_due.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// a response leaving at this edge belongs to an earlier request
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: response with no request waiting: %s %0d cell_state %0d",
						$time, "expected none, got done_action", m_tuser, m_tdata[0]);
					mismatches++;
				end else begin
					due = replies_due.pop_front();
					if (m_tuser !== due.action) begin
						$display("%0t: done_action mismatch: expected %s, got %0d",
							$time, due.action.name(), m_tuser);
						mismatches++;
					end
					if (m_tdata[0] !== due.cell_val) begin
						$display("%0t: cell_state mismatch (%s): expected %0d, got %0d",
							$time, due.action.name(), due.cell_val, m_tdata[0]);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BIRTH)
					birth_rule = cfg_data;
				else
					survive_rule = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				req_col = int'(s_tdata[5:0]);
				req_row = int'(s_tdata[11:6]);
				req_paint = s_tdata[12];
				on_board = (req_col < GRID_WIDTH) && (req_row < GRID_HEIGHT);
				due.action = act_t'(s_tuser);
				due.cell_val = 1'b0;
				case (act_t'(s_tuser))
					ACT_WRITE: begin
						if (on_board)
							board[req_row][req_col] = req_paint;
					end
					ACT_CLEAR: begin
						for (int y = 0; y < GRID_HEIGHT; y++)
							board[y] = '0;
					end
					ACT_ADVANCE: begin
						step_generation();
					end
					ACT_READ: begin
						if (on_board)
							due.cell_val = board[req_row][req_col];
					end
					default: ;
				endcase
				replies_due.push_back(due);
			end
			outstanding <= replies_due.size();
		end
	end

endmodule

### tb/sv/tb_life_like_automaton_generation_top.sv
`timescale 1ns / 1ps

module tb_life_like_automaton_generation_top;
	import lla_pkg::*;

	localparam int GRID_WIDTH = 64;
	localparam int GRID_HEIGHT = 64;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = GRID_HEIGHT + 16;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;
	logic [1:0]        m_tuser;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [MASK_W-1:0] cfg_data;

	int mismatch_count;
	int outstanding;
	int send_idle_pct;
	int recv_idle_pct;
	int requests_sent;
	int sent_by_action [4];
	int idle_cycles;

	logic [MASK_W-1:0] birth_set [PHASES];
	logic [MASK_W-1:0] survive_set [PHASES];

	life_like_automaton_generation_top #(
		.GRID_WIDTH(GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	life_like_automaton_generation_checker #(
		.GRID_WIDTH(GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d responses outstanding",
					$time, STALL_LIMIT, outstanding);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// valid stays high from one request to the next unless a gap is drawn
	task automatic send_request(input act_t act, input int col, input int row, input bit paint);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, paint, row[COORD_W-1:0], col[COORD_W-1:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
		sent_by_action[act]++;
	endtask

	task automatic drain_responses();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// block must be idle: called only after drain_responses
	task automatic load_masks(input logic [MASK_W-1:0] birth, input logic [MASK_W-1:0] survive);
		cfg_valid <= 1'b1;
		cfg_index <= REG_BIRTH;
		cfg_data <= birth;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_SURVIVE;
		cfg_data <= survive;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int org_c, org_r, phase_start;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_WRITE;
		cfg_valid <= 1'b0;
		cfg_index <= REG_BIRTH;
		cfg_data <= '0;
		requests_sent = 0;
		for (int a = 0; a < 4; a++)
			sent_by_action[a] = 0;
		send_idle_pct = 13;
		recv_idle_pct = 78;

		birth_set[0] = 9'd8;    survive_set[0] = 9'd12;
		birth_set[1] = 9'd0;    survive_set[1] = 9'd0;
		birth_set[2] = 9'h1FF;  survive_set[2] = 9'h1FF;
		birth_set[3] = 9'd72;   survive_set[3] = 9'd12;
		birth_set[4] = 9'h1FF;  survive_set[4] = 9'd0;
		birth_set[5] = 9'd0;    survive_set[5] = 9'h1FF;
		birth_set[6] = 9'd456;  survive_set[6] = 9'd440;
		birth_set[7] = 9'($urandom_range(511));
		survive_set[7] = 9'($urandom_range(511));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part on the reset masks; the first read waits out the clearing pass
		send_request(ACT_READ, 0, 0, 1'b0);
		// four corners are neighbours of each other across the wrap
		send_request(ACT_WRITE, 0, 0, 1'b1);
		send_request(ACT_WRITE, 63, 63, 1'b1);
		send_request(ACT_WRITE, 63, 0, 1'b1);
		send_request(ACT_WRITE, 0, 63, 1'b1);
		send_request(ACT_READ, 63, 63, 1'b0);
		send_request(ACT_ADVANCE, 0, 0, 1'b0);
		send_request(ACT_READ, 0, 0, 1'b0);
		send_request(ACT_READ, 1, 1, 1'b0);
		send_request(ACT_WRITE, 0, 0, 1'b0);
		send_request(ACT_READ, 0, 0, 1'b0);
		send_request(ACT_ADVANCE, 63, 63, 1'b1);
		send_request(ACT_READ, 0, 0, 1'b0);
		send_request(ACT_CLEAR, 63, 63, 1'b1);
		send_request(ACT_READ, 63, 63, 1'b0);
		// blinker in the middle
		send_request(ACT_WRITE, 31, 30, 1'b1);
		send_request(ACT_WRITE, 31, 31, 1'b1);
		send_request(ACT_WRITE, 31, 32, 1'b1);
		send_request(ACT_ADVANCE, 0, 0, 1'b0);
		send_request(ACT_READ, 30, 31, 1'b1);
		send_request(ACT_READ, 31, 30, 1'b0);
		send_request(ACT_ADVANCE, 0, 0, 1'b0);
		send_request(ACT_READ, 31, 30, 1'b0);
		send_request(ACT_READ, 42, 21, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			drain_responses();
			load_masks(birth_set[p], survive_set[p]);
			if (p < 3) begin
				send_idle_pct = 13;
				recv_idle_pct = 78;
			end else if (p < 6) begin
				send_idle_pct = 78;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			phase_start = requests_sent;
			while (requests_sent - phase_start < ITEMS_PER_PHASE) begin
				// seed a small window, run a few generations and look in and around it
				org_c = $urandom_range(63);
				org_r = $urandom_range(63);
				repeat ($urandom_range(4, 12))
					send_request(ACT_WRITE, (org_c + $urandom_range(5)) % 64,
						(org_r + $urandom_range(5)) % 64, $urandom_range(99) < 80);
				repeat ($urandom_range(1, 3)) begin
					send_request(ACT_ADVANCE, $urandom_range(63), $urandom_range(63),
						$urandom_range(1));
					repeat ($urandom_range(2, 6))
						send_request(ACT_READ, (org_c + $urandom_range(7)) % 64,
							(org_r + $urandom_range(7)) % 64, $urandom_range(1));
				end
				if ($urandom_range(99) < 20)
					send_request(act_t'($urandom_range(3)), $urandom_range(63),
						$urandom_range(63), $urandom_range(1));
				if ($urandom_range(99) < 4)
					send_request(ACT_CLEAR, $urandom_range(63), $urandom_range(63),
						$urandom_range(1));
				if ($urandom_range(99) < 3)
					drain_responses();
			end
		end

		drain_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d writes, %0d clears, %0d generations, %0d reads",
			requests_sent, sent_by_action[ACT_WRITE], sent_by_action[ACT_CLEAR],
			sent_by_action[ACT_ADVANCE], sent_by_action[ACT_READ]);
		$display("over the reset rule and %0d mask settings, with both sides stalling in turn",
			PHASES);
		if (mismatch_count == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
